@@ hw/rtl/lebuf_pkg.sv @@
// Shared types and constants for the line edit buffer core.
// No dependencies; imported by line_edit_buffer_core and lebuf_chk.
package lebuf_pkg;

    localparam int unsigned BUFFER_DEPTH_DEF = 256;
    localparam int unsigned PROMPT_W         = 12;
    localparam int unsigned OFFSET_W         = 13;

    // Edit command codes carried in the mode field
    typedef enum logic [3:0] {
        MODE_INSERT    = 4'd0,
        MODE_BACKSPACE = 4'd1,
        MODE_DELETE    = 4'd2,
        MODE_LEFT      = 4'd3,
        MODE_RIGHT     = 4'd4,
        MODE_HOME      = 4'd5,
        MODE_END       = 4'd6,
        MODE_CLEAR     = 4'd7,
        MODE_READ      = 4'd8
    } lebuf_mode_t;

    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] char_in;
        logic [7:0] read_index;
    } lebuf_in_t;

    typedef struct packed {
        logic [7:0]          line_length;
        logic [7:0]          cursor_pos;
        logic [OFFSET_W-1:0] cursor_offset;
        logic                changed;
        logic                accepted;
        logic [7:0]          read_char;
    } lebuf_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SHIFT_R,
        ST_INS_WR,
        ST_SHIFT_L,
        ST_RD_WAIT,
        ST_RESP
    } lebuf_state_t;

endpackage

@@ hw/rtl/line_edit_buffer_core.sv @@
// Line edit buffer core: character line in a synchronous RAM, length and cursor registers.
// Depends on lebuf_pkg.
//
// Commands that do not touch the RAM run through EXEC and RESP; a read inside the line also passes
// through RD_WAIT. Insert shifts any tail right in SHIFT_R, then writes in INS_WR; backspace and
// delete shift any tail left in SHIFT_L: one RAM port moves a character a cycle.
// One command is in work at a time; the next input beat is taken once the result sits in the
// output register, so a new command is not taken before the last one is through.
// Reset clears length, cursor, prompt offset and the handshake state; the RAM is not cleared.
module line_edit_buffer_core #(
    parameter int unsigned BUFFER_DEPTH = lebuf_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lebuf_pkg::lebuf_in_t              in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lebuf_pkg::lebuf_out_t             out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lebuf_pkg::PROMPT_W-1:0]    cfg_data
);
    import lebuf_pkg::*;

    // Index width: length never exceeds BUFFER_DEPTH-1, so AW bits hold it.
    localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    // Compare width for the 8-bit read index against the length.
    localparam int unsigned CW = (AW > 8) ? AW : 8;

    // ---------------- state ----------------
    lebuf_state_t      state_reg, state_next;
    logic [AW-1:0]     len_reg, len_next;
    logic [AW-1:0]     cur_reg, cur_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;   // RAM address read in the previous cycle
    logic [PROMPT_W-1:0] prompt_reg;
    logic [3:0]        mode_reg, mode_next;
    logic [7:0]        char_reg, char_next;
    logic [7:0]        ridx_reg, ridx_next;
    logic              chg_reg, chg_next;
    logic              acc_reg, acc_next;
    logic [7:0]        rchar_reg, rchar_next;
    logic              out_valid_reg, out_valid_next;
    lebuf_out_t        out_reg, out_next;

    // ---------------- line RAM ----------------
    logic [7:0]        line_mem [BUFFER_DEPTH];
    logic [7:0]        mem_rdata_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_wdata;
    logic [AW-1:0]     mem_raddr;

    // Single write port, one registered read port. Shifts run the read two addresses
    // ahead of the write, so a shift cycle never reads the entry it writes.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= line_mem[mem_raddr];
    end

    // ---------------- handshakes ----------------
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;   // config to be written only while idle; the core does not enforce it

    logic          out_free;
    logic [AW-1:0] del_pos;    // first position overwritten by a left shift
    assign out_free = !out_valid_reg || out_ready;
    assign del_pos  = (mode_reg == MODE_BACKSPACE) ? (cur_reg - 1'b1) : cur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            cur_reg       <= '0;
            prompt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                prompt_reg <= cfg_data;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        mode_reg    <= mode_next;
        char_reg    <= char_next;
        ridx_reg    <= ridx_next;
        chg_reg     <= chg_next;
        acc_reg     <= acc_next;
        rchar_reg   <= rchar_next;
        out_reg     <= out_next;
    end

    // ---------------- command sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        cur_next       = cur_reg;
        rd_addr_next   = rd_addr_reg;
        mode_next      = mode_reg;
        char_next      = char_reg;
        ridx_next      = ridx_reg;
        chg_next       = chg_reg;
        acc_next       = acc_reg;
        rchar_next     = rchar_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_we         = 1'b0;
        mem_waddr      = rd_addr_reg;
        mem_wdata      = mem_rdata_reg;
        mem_raddr      = rd_addr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = in_data.mode;
                    char_next  = in_data.char_in;
                    ridx_next  = in_data.read_index;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                chg_next   = 1'b0;
                acc_next   = 1'b0;
                rchar_next = 8'd0;
                state_next = ST_RESP;
                case (mode_reg)
                    MODE_INSERT:
                    begin
                        if (len_reg < AW'(BUFFER_DEPTH - 1))
                        begin
                            if (len_reg > cur_reg)
                            begin
                                // tail moves right, starting from the last character
                                mem_raddr    = len_reg - 1'b1;
                                rd_addr_next = len_reg - 1'b1;
                                state_next   = ST_SHIFT_R;
                            end
                            else
                            begin
                                state_next = ST_INS_WR;
                            end
                        end
                    end
                    MODE_BACKSPACE, MODE_DELETE:
                    begin
                        if ((mode_reg == MODE_BACKSPACE) ? (cur_reg != '0) : (cur_reg < len_reg))
                        begin
                            chg_next = 1'b1;
                            acc_next = 1'b1;
                            if ((del_pos + 1'b1) < len_reg)
                            begin
                                mem_raddr    = del_pos + 1'b1;
                                rd_addr_next = del_pos + 1'b1;
                                state_next   = ST_SHIFT_L;
                            end
                            else
                            begin
                                len_next = len_reg - 1'b1;
                                if (mode_reg == MODE_BACKSPACE)
                                begin
                                    cur_next = cur_reg - 1'b1;
                                end
                            end
                        end
                    end
                    MODE_LEFT:
                    begin
                        if (cur_reg != '0)
                        begin
                            cur_next = cur_reg - 1'b1;
                            acc_next = 1'b1;
                        end
                    end
                    MODE_RIGHT:
                    begin
                        if (cur_reg < len_reg)
                        begin
                            cur_next = cur_reg + 1'b1;
                            acc_next = 1'b1;
                        end
                    end
                    MODE_HOME:
                    begin
                        cur_next = '0;
                        acc_next = 1'b1;
                    end
                    MODE_END:
                    begin
                        cur_next = len_reg;
                        acc_next = 1'b1;
                    end
                    MODE_CLEAR:
                    begin
                        chg_next = (len_reg != '0);
                        acc_next = 1'b1;
                        len_next = '0;
                        cur_next = '0;
                    end
                    MODE_READ:
                    begin
                        acc_next = 1'b1;
                        if (CW'(ridx_reg) < CW'(len_reg))
                        begin
                            mem_raddr  = AW'(ridx_reg);
                            state_next = ST_RD_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RESP;   // unused codes: no effect
                    end
                endcase
            end

            ST_SHIFT_R:
            begin
                // data read last cycle from rd_addr goes one place up
                mem_we    = 1'b1;
                mem_waddr = rd_addr_reg + 1'b1;
                if (rd_addr_reg > cur_reg)
                begin
                    mem_raddr    = rd_addr_reg - 1'b1;
                    rd_addr_next = rd_addr_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_INS_WR;
                end
            end

            ST_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cur_reg;
                mem_wdata  = char_reg;
                len_next   = len_reg + 1'b1;
                cur_next   = cur_reg + 1'b1;
                chg_next   = 1'b1;
                acc_next   = 1'b1;
                state_next = ST_RESP;
            end

            ST_SHIFT_L:
            begin
                // data read last cycle from rd_addr goes one place down
                mem_we    = 1'b1;
                mem_waddr = rd_addr_reg - 1'b1;
                if ((rd_addr_reg + 1'b1) < len_reg)
                begin
                    mem_raddr    = rd_addr_reg + 1'b1;
                    rd_addr_next = rd_addr_reg + 1'b1;
                end
                else
                begin
                    len_next = len_reg - 1'b1;
                    if (mode_reg == MODE_BACKSPACE)
                    begin
                        cur_next = cur_reg - 1'b1;
                    end
                    state_next = ST_RESP;
                end
            end

            ST_RD_WAIT:
            begin
                rchar_next = mem_rdata_reg;
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_next.line_length   = 8'(len_reg);
                    out_next.cursor_pos    = 8'(cur_reg);
                    out_next.cursor_offset = OFFSET_W'({1'b0, prompt_reg})
                                           + OFFSET_W'({cur_reg, 1'b0});
                    out_next.changed       = chg_reg;
                    out_next.accepted      = acc_reg;
                    out_next.read_char     = rchar_reg;
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/lebuf_chk.sv @@
// Port-level checker for line_edit_buffer_core, bound to every instance.
// Depends on lebuf_pkg and line_edit_buffer_core.
module lebuf_chk #(
    parameter int unsigned BUFFER_DEPTH = lebuf_pkg::BUFFER_DEPTH_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input lebuf_pkg::lebuf_in_t           in_data,
    input logic                           out_valid,
    input logic                           out_ready,
    input lebuf_pkg::lebuf_out_t          out_data,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [lebuf_pkg::PROMPT_W-1:0] cfg_data
);
    import lebuf_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // one command at a time: busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a command is in work");

    a_changed_implies_acc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.changed |-> out_data.accepted)
        else $error("changed without accepted");

    a_refused_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.accepted |-> out_data.read_char == 8'd0 && !out_data.changed)
        else $error("refused command reports data");

    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (BUFFER_DEPTH <= 256) && out_valid |-> out_data.cursor_pos <= out_data.line_length)
        else $error("cursor beyond line end");

endmodule

bind line_edit_buffer_core lebuf_chk #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_lebuf_chk (.*);

@@ tb/sv/tb_line_edit_buffer_core.sv @@
// Self-checking testbench for line_edit_buffer_core: edit command beats in, line status beats out.
// Depends on lebuf_pkg and the core RTL; runs standalone, predicting every result internally.
module tb_line_edit_buffer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lebuf_pkg::*;

    localparam int unsigned LINE_DEPTH  = BUFFER_DEPTH_DEF;
    // Worst correct gap between beats is an insert at the head of a line one short of full
    // plus a long receiver stall; this is many times that.
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned PHASE_ITEMS = 470;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    lebuf_in_t           in_data    = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    lebuf_out_t          out_data;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic [PROMPT_W-1:0] cfg_data   = '0;

    // Shadow copy of the editor: the line, its length, the cursor and the prompt offset.
    // Entries of model_line are only read below model_len, i.e. after being written.
    logic [7:0]          model_line [0:LINE_DEPTH-1];
    int unsigned         model_len    = 0;
    int unsigned         model_cur    = 0;
    logic [PROMPT_W-1:0] model_prompt = '0;

    lebuf_in_t   edit_cmds_q[$];       // commands waiting to be driven
    lebuf_out_t  edit_results_due[$];  // predicted status beats, oldest first
    lebuf_out_t  due_status;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;

    always #5 clk = ~clk;

    line_edit_buffer_core #(
        .BUFFER_DEPTH (LINE_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Apply one edit command to the shadow line and return the status beat it must produce.
    function automatic lebuf_out_t apply_edit(input lebuf_in_t cmd);
        lebuf_out_t  status;
        int unsigned k;
        status = '0;
        case (lebuf_mode_t'(cmd.mode))
            MODE_INSERT:
            begin
                // refused once the line is one short of the store depth
                if (model_len < LINE_DEPTH - 1)
                begin
                    for (k = model_len; k > model_cur; k--)
                        model_line[k] = model_line[k - 1];
                    model_line[model_cur] = cmd.char_in;
                    model_cur++;
                    model_len++;
                    status.changed  = 1'b1;
                    status.accepted = 1'b1;
                end
            end
            MODE_BACKSPACE:
            begin
                if (model_cur > 0)
                begin
                    for (k = model_cur - 1; k + 1 < model_len; k++)
                        model_line[k] = model_line[k + 1];
                    model_len--;
                    model_cur--;
                    status.changed  = 1'b1;
                    status.accepted = 1'b1;
                end
            end
            MODE_DELETE:
            begin
                if (model_cur < model_len)
                begin
                    for (k = model_cur; k + 1 < model_len; k++)
                        model_line[k] = model_line[k + 1];
                    model_len--;
                    status.changed  = 1'b1;
                    status.accepted = 1'b1;
                end
            end
            MODE_LEFT:
            begin
                if (model_cur > 0)
                begin
                    model_cur--;
                    status.accepted = 1'b1;
                end
            end
            MODE_RIGHT:
            begin
                if (model_cur < model_len)
                begin
                    model_cur++;
                    status.accepted = 1'b1;
                end
            end
            MODE_HOME:
            begin
                model_cur = 0;
                status.accepted = 1'b1;
            end
            MODE_END:
            begin
                model_cur = model_len;
                status.accepted = 1'b1;
            end
            MODE_CLEAR:
            begin
                status.changed  = (model_len != 0);
                model_len = 0;
                model_cur = 0;
                status.accepted = 1'b1;
            end
            MODE_READ:
            begin
                if (cmd.read_index < model_len)
                    status.read_char = model_line[cmd.read_index];
                status.accepted = 1'b1;
            end
            default:
            begin
                // unassigned codes: no effect, nothing accepted
            end
        endcase
        status.line_length   = model_len[7:0];
        status.cursor_pos    = model_cur[7:0];
        status.cursor_offset = OFFSET_W'(model_prompt + 2 * model_cur);
        return status;
    endfunction

    function automatic void queue_cmd(input logic [3:0] mode, input logic [7:0] ch,
                                      input logic [7:0] idx);
        lebuf_in_t cmd;
        cmd.mode       = mode;
        cmd.char_in    = ch;
        cmd.read_index = idx;
        edit_cmds_q.push_back(cmd);
    endfunction

    task automatic check_field(input string name, input logic [15:0] expd,
                               input logic [15:0] got);
        if (got !== expd)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, expd, got);
            mismatch_count++;
        end
    endtask

    // Command driver: holds a beat until accepted, predicts it on the accepting edge,
    // then either presents the next queued command or idles at the current rate.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                edit_results_due.push_back(apply_edit(in_data));
            if (!in_valid || in_ready)
            begin
                if (edit_cmds_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= edit_cmds_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Status monitor: every accepted beat must match the oldest prediction, field by field.
    // out_ready is redrawn every cycle so stalls land on every part of the core's work.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (edit_results_due.size() == 0)
                begin
                    $error("status beat with no command outstanding");
                    mismatch_count++;
                end
                else
                begin
                    due_status = edit_results_due.pop_front();
                    check_field("line_length", due_status.line_length, out_data.line_length);
                    check_field("cursor_pos", due_status.cursor_pos, out_data.cursor_pos);
                    check_field("cursor_offset", due_status.cursor_offset,
                                out_data.cursor_offset);
                    check_field("changed", due_status.changed, out_data.changed);
                    check_field("accepted", due_status.accepted, out_data.accepted);
                    check_field("read_char", due_status.read_char, out_data.read_char);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: any beat on any channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("** line_edit_buffer_core: FAILED **");
                $finish;
            end
        end
    end

    // Prompt offset write; the shadow copy follows on the accepting edge.
    task automatic write_prompt(input logic [PROMPT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        model_prompt = value;
        cfg_valid <= 1'b0;
    endtask

    // Sender holds off until every queued command is out and every status beat is back,
    // then lets the core settle before returning. Checked mid-cycle so the driver's
    // edge updates are already visible.
    task automatic drain(input int unsigned settle);
        while (edit_cmds_q.size() != 0 || in_valid || edit_results_due.size() != 0)
            @(negedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Random editing session. Inserts dominate so the line grows to useful lengths,
    // with occasional clears pulling it back; a few beats carry unassigned codes.
    task automatic edit_session(input int unsigned count);
        int unsigned pick;
        int unsigned n;
        logic [7:0]  idx;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            idx  = $urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom);
            if (pick < 40)
                queue_cmd(MODE_INSERT, 8'($urandom), 8'($urandom));
            else if (pick < 50)
                queue_cmd(MODE_BACKSPACE, 8'($urandom), 8'($urandom));
            else if (pick < 58)
                queue_cmd(MODE_DELETE, 8'($urandom), 8'($urandom));
            else if (pick < 66)
                queue_cmd(MODE_LEFT, 8'($urandom), 8'($urandom));
            else if (pick < 74)
                queue_cmd(MODE_RIGHT, 8'($urandom), 8'($urandom));
            else if (pick < 78)
                queue_cmd(MODE_HOME, 8'($urandom), 8'($urandom));
            else if (pick < 82)
                queue_cmd(MODE_END, 8'($urandom), 8'($urandom));
            else if (pick < 84)
                queue_cmd(MODE_CLEAR, 8'($urandom), 8'($urandom));
            else if (pick < 96)
                queue_cmd(MODE_READ, 8'($urandom), idx);
            else
                queue_cmd(4'($urandom_range(15, int'(MODE_READ) + 1)), 8'($urandom),
                          8'($urandom));
        end
    endtask

    initial
    begin
        int unsigned n;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass: every command, both ends of each field, every refusal but a full-line insert.
        send_idle_pct = 12;
        recv_idle_pct = 78;
        write_prompt(12'd4000);
        queue_cmd(MODE_BACKSPACE, 8'h00, 8'h00);   // nothing before the cursor
        queue_cmd(MODE_DELETE,    8'h00, 8'h00);   // nothing under the cursor
        queue_cmd(MODE_LEFT,      8'h00, 8'h00);   // already at start
        queue_cmd(MODE_RIGHT,     8'hFF, 8'hFF);   // already at end
        queue_cmd(MODE_READ,      8'hFF, 8'h00);   // empty line reads 0
        queue_cmd(MODE_CLEAR,     8'h00, 8'h00);   // clear of an empty line: no change
        queue_cmd(MODE_INSERT,    8'h00, 8'hFF);
        queue_cmd(MODE_INSERT,    8'hFF, 8'h00);
        queue_cmd(MODE_LEFT,      8'h00, 8'h00);
        queue_cmd(MODE_INSERT,    8'hA5, 8'h5A);   // insert mid-line
        queue_cmd(MODE_HOME,      8'h00, 8'h00);
        queue_cmd(MODE_INSERT,    8'h5A, 8'h00);   // insert at head
        queue_cmd(MODE_DELETE,    8'h00, 8'h00);
        queue_cmd(MODE_END,       8'h00, 8'h00);
        queue_cmd(MODE_BACKSPACE, 8'h00, 8'h00);
        queue_cmd(MODE_READ,      8'h00, 8'h00);
        queue_cmd(MODE_READ,      8'h00, 8'h01);   // last character of the line
        queue_cmd(MODE_READ,      8'hFF, 8'hFF);   // far beyond the length
        queue_cmd(4'(int'(MODE_READ) + 1), 8'hFF, 8'hFF);   // unassigned codes do nothing
        queue_cmd(4'hF,           8'h3C, 8'h00);
        queue_cmd(MODE_CLEAR,     8'h00, 8'h00);   // non-empty clear flags a change
        drain(8);

        // Session one: sender mostly busy, receiver mostly stalled.
        write_prompt('0);
        edit_session(PHASE_ITEMS);
        drain(8);

        // Session two: roles swapped.
        send_idle_pct = 78;
        recv_idle_pct = 12;
        write_prompt(PROMPT_W'($urandom_range(4000)));
        edit_session(PHASE_ITEMS);
        drain(8);

        // Session three at full rate, opened by filling the line until inserts bounce,
        // then long shifts at the head of a full line.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_prompt(12'd4000);
        queue_cmd(MODE_CLEAR, 8'h00, 8'h00);
        for (n = 0; n < LINE_DEPTH + 2; n++)
            queue_cmd(MODE_INSERT, 8'($urandom), 8'($urandom));
        queue_cmd(MODE_READ,      8'h00, 8'd254);
        queue_cmd(MODE_READ,      8'h00, 8'd255);
        queue_cmd(MODE_RIGHT,     8'h00, 8'h00);
        queue_cmd(MODE_HOME,      8'h00, 8'h00);
        queue_cmd(MODE_INSERT,    8'h41, 8'h00);   // full line, refused at the head too
        queue_cmd(MODE_DELETE,    8'h00, 8'h00);
        queue_cmd(MODE_INSERT,    8'h42, 8'h00);
        queue_cmd(MODE_READ,      8'h00, 8'h00);
        queue_cmd(MODE_BACKSPACE, 8'h00, 8'h00);
        queue_cmd(MODE_END,       8'h00, 8'h00);
        queue_cmd(MODE_BACKSPACE, 8'h00, 8'h00);
        queue_cmd(MODE_CLEAR,     8'h00, 8'h00);
        edit_session(PHASE_ITEMS);
        drain(20);

        if (mismatch_count == 0 && edit_results_due.size() == 0)
            $display("** line_edit_buffer_core: PASSED **");
        else
            $display("** line_edit_buffer_core: FAILED **");
        $finish;
    end

endmodule
